### rtl/wheel_imu_odometry_unit_defines.svh
// Assertion macros shared by the checker of the wheel and IMU odometry unit.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef WHEEL_IMU_ODOMETRY_UNIT_DEFINES_SVH
`define WHEEL_IMU_ODOMETRY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIO_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define WIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry checker: next-cycle property failed");

`endif

### rtl/wio_pkg.sv
// Package of the wheel and IMU odometry unit: item types, fixed-point constants
// and the arctangent table of the rotation iterations. Depends on nothing.
package wio_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int APB_AW = 4;

  localparam logic [19:0] KRAD = 20'd749613;          // pi/18000 in Q32
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 24;
  localparam logic [19:0] US_SCALE = 20'd1000000;
  localparam logic [40:0] V0_CAP = 41'd1 << 40;
  localparam logic [49:0] F_CAP = 50'd1 << 49;

  typedef struct packed {
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [15:0]        heading_cdeg;
    logic [23:0]        elapsed_us;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [18:0]        yaw_rad;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
  } odo_out_t;

  // Rotation angle of step i in Q30.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic [4:0] sh;
    sh = 5'd30 - i;
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      default: atan_q30 = 34'sd1 <<< sh;
    endcase
  endfunction

endpackage

### rtl/wheel_imu_odometry_unit.sv
// Top level of the wheel and IMU odometry unit: sequencer, shared multiplier,
// rotation unit and divider. Depends on wio_pkg.
//
// The time from one accepted update item to the next is shortest when the
// elapsed time is zero, longer when the heading did not change and longest when
// it did (less when the sine of the turn comes out zero). The times come from the
// 74-step restoring divider and the 24 rotation iterations. The divider runs
// once for the forward speed and up to twice more on a turn. The rotation runs
// once for the position and once more on a turn. in_ready is high only while
// the sequencer is idle. The result sits in an output register, so the next item
// can be taken while it waits. A finished item whose result finds that register
// still occupied holds the sequencer until the waiting result is taken.
module wheel_imu_odometry_unit #(
  parameter int POS_FRAC_BITS = wio_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wio_pkg::odo_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wio_pkg::odo_out_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wio_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import wio_pkg::*;

  localparam int SHIFT = 24 - POS_FRAC_BITS;
  localparam logic signed [54:0] DP_RND = (55'sd1 <<< SHIFT) >>> 1;
  localparam int DIV_W = 74;

  localparam logic [1:0] REG_DPT = 2'd0;
  localparam logic [1:0] REG_LSTART = 2'd1;
  localparam logic [1:0] REG_RSTART = 2'd2;

  typedef enum logic [25:0] {
    S_IDLE   = 26'h0000001, S_DIST = 26'h0000002, S_YAW  = 26'h0000004,
    S_TZ     = 26'h0000008, S_CINIT = 26'h0000010, S_CORD = 26'h0000020,
    S_CEND   = 26'h0000040, S_PX   = 26'h0000080, S_PY   = 26'h0000100,
    S_ACCY   = 26'h0000200, S_V2   = 26'h0000400, S_V3   = 26'h0000800,
    S_DIV    = 26'h0001000, S_DIVEND = 26'h0002000, S_N1 = 26'h0004000,
    S_N2     = 26'h0008000, S_FSET = 26'h0010000, S_A1   = 26'h0020000,
    S_A2     = 26'h0040000, S_M1   = 26'h0080000, S_M2   = 26'h0100000,
    S_M3     = 26'h0200000, S_M4   = 26'h0400000, S_M5   = 26'h0800000,
    S_M6     = 26'h1000000, S_DONE = 26'h2000000
  } state_t;

  typedef enum logic [1:0] {DIV_V0, DIV_F, DIV_ANG} div_op_t;

  state_t state;
  div_op_t div_op;

  // configuration and kept state
  logic [19:0]        dpt;
  logic [31:0]        left_start, right_start;
  logic signed [31:0] acc_x, acc_y;
  logic [31:0]        last_left, last_right;
  logic [15:0]        last_heading;
  logic               first_seen;

  // item registers
  logic [31:0]        l_q, r_q;
  logic [15:0]        h_q;
  logic [23:0]        us_q;
  logic signed [32:0] dsum;
  logic               n_zero, n_neg;
  logic [15:0]        an;
  logic signed [53:0] dist_q;
  logic signed [31:0] dp;
  logic [18:0]        yaw_q;
  logic [32:0]        dth;
  logic [40:0]        v0;
  logic [49:0]        f_q;
  logic signed [31:0] lin_q, ang_q;
  logic [95:0]        macc;

  // rotation unit
  logic [15:0]        trig_h;
  logic               trig_pass, trig_cneg, trig_aneg;
  logic signed [33:0] cx, cy, cz, cv, sv;
  logic [4:0]         cord_i;

  // divider
  logic [DIV_W-1:0]   div_num;
  logic [40:0]        div_rem;
  logic [39:0]        div_den;
  logic [6:0]         div_cnt;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -40'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] sigmag(input logic [73:0] mag, input logic neg);
    if (neg) sigmag = (mag > 74'd2147483648) ? 32'sh80000000 : -$signed(mag[31:0]);
    else sigmag = (mag > 74'd2147483647) ? 32'sh7fffffff : $signed(mag[31:0]);
  endfunction

  logic        accept, cfg_wr;
  logic [15:0] h_in;
  logic [15:0] p_h;
  logic signed [17:0] n_c;
  logic [31:0] dl, dr, refl, refr;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_DPT:    prdata = {12'b0, dpt};
      REG_LSTART: prdata = left_start;
      REG_RSTART: prdata = right_start;
      default:    prdata = 32'b0;
    endcase
  end

  // Heading change across the 0/360 degree seam, and the count deltas.
  always_comb begin
    h_in = (in_data.heading_cdeg > 16'd35999) ? 16'd35999 : in_data.heading_cdeg;
    p_h = last_heading;
    if (h_in >= 16'd35500 && p_h <= 16'd500)
      n_c = $signed({2'b0, p_h}) + 18'sd36000 - $signed({2'b0, h_in});
    else if (h_in <= 16'd500 && p_h >= 16'd35500)
      n_c = $signed({2'b0, p_h}) - $signed({2'b0, h_in}) - 18'sd36000;
    else
      n_c = $signed({2'b0, p_h}) - $signed({2'b0, h_in});
    refl = first_seen ? last_left : left_start;
    refr = first_seen ? last_right : right_start;
    dl = in_data.left_ticks - refl;
    dr = in_data.right_ticks - refr;
  end

  // Angle reduction to the first quadrant.
  logic [13:0] amag;
  logic        a_neg, a_cneg;
  always_comb begin
    logic [15:0] t;
    t = 16'd0;
    if (trig_h <= 16'd9000) begin
      t = trig_h; a_neg = 1'b0; a_cneg = 1'b0;
    end else if (trig_h <= 16'd27000) begin
      a_cneg = 1'b1;
      a_neg = trig_h > 16'd18000;
      t = a_neg ? trig_h - 16'd18000 : 16'd18000 - trig_h;
    end else begin
      a_cneg = 1'b0; a_neg = 1'b1;
      t = 16'd36000 - trig_h;
    end
    amag = t[13:0];
  end

  logic [52:0] dmag;
  assign dmag = dist_q[53] ? 53'(-dist_q) : dist_q[52:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DIST: begin mul_a = 34'(dsum); mul_b = {14'b0, dpt}; end
      S_YAW:  begin mul_a = {18'b0, 16'd36000 - h_q}; mul_b = {14'b0, KRAD}; end
      S_TZ:   begin mul_a = {20'b0, amag}; mul_b = {14'b0, KRAD}; end
      S_PX:   begin mul_a = 34'(dp); mul_b = cv; end
      S_PY:   begin mul_a = 34'(dp); mul_b = -sv; end
      S_ACCY: begin mul_a = {2'b0, dmag[31:0]}; mul_b = {14'b0, US_SCALE}; end
      S_V2:   begin mul_a = {13'b0, dmag[52:32]}; mul_b = {14'b0, US_SCALE}; end
      S_N1:   begin mul_a = {18'b0, an}; mul_b = {14'b0, KRAD}; end
      S_A1:   begin mul_a = {1'b0, dth}; mul_b = {14'b0, US_SCALE}; end
      S_M1:   begin mul_a = {2'b0, v0[31:0]}; mul_b = {2'b0, f_q[31:0]}; end
      S_M2:   begin mul_a = {2'b0, v0[31:0]}; mul_b = {16'b0, f_q[49:32]}; end
      S_M3:   begin mul_a = {25'b0, v0[40:32]}; mul_b = {2'b0, f_q[31:0]}; end
      S_M4:   begin mul_a = {25'b0, v0[40:32]}; mul_b = {16'b0, f_q[49:32]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Combinational helpers read from registers only.
  logic signed [67:0] acc_term;
  logic signed [39:0] accx_sum, accy_sum;
  logic [35:0]        rnd2, rnd16;
  logic signed [54:0] dp_wide;
  logic [40:0]        rem_s;
  logic [41:0]        rem_d;
  logic signed [33:0] dx, dy, atv;
  logic [95:0]        prod_lo, prod_sh32, prod_sh64;
  logic [33:0]        smag;

  always_comb begin
    acc_term = (prod_q + (68'sd1 <<< 29)) >>> 30;
    accx_sum = 40'(acc_x) + acc_term[39:0];
    accy_sum = 40'(acc_y) + acc_term[39:0];
    rnd2 = prod_q[35:0] + 36'd2;
    rnd16 = prod_q[35:0] + 36'd32768;
    dp_wide = (55'(dist_q) + DP_RND) >>> SHIFT;
    rem_s = {div_rem[39:0], div_num[DIV_W-1]};
    rem_d = {1'b0, rem_s} - {2'b0, div_den};
    dx = cy >>> cord_i;
    dy = cx >>> cord_i;
    atv = atan_q30(cord_i);
    prod_lo = {32'b0, prod_q[63:0]};
    prod_sh32 = {prod_q[63:0], 32'b0};
    prod_sh64 = {prod_q[31:0], 64'b0};
    smag = sv[33] ? 34'(-sv) : sv;
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      first_seen <= 1'b0;
      last_left <= '0;
      last_right <= '0;
      last_heading <= '0;
      acc_x <= '0;
      acc_y <= '0;
      dpt <= 20'd10541;
      left_start <= '0;
      right_start <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_DPT:    dpt <= pwdata[19:0];
          REG_LSTART: left_start <= pwdata;
          REG_RSTART: right_start <= pwdata;
          default:    ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            l_q <= in_data.left_ticks;
            r_q <= in_data.right_ticks;
            h_q <= h_in;
            us_q <= in_data.elapsed_us;
            dsum <= 33'($signed(dl)) + 33'($signed(dr));
            n_zero <= !first_seen || (n_c == 18'sd0);
            n_neg <= first_seen && n_c[17];
            an <= n_c[17] ? 16'(-n_c) : n_c[15:0];
            trig_h <= h_in;
            trig_pass <= 1'b0;
            lin_q <= '0;
            ang_q <= '0;
            state <= S_DIST;
          end
        end
        S_DIST: state <= S_YAW;
        S_YAW: begin
          dist_q <= prod_q[53:0];
          state <= S_TZ;
        end
        S_TZ: begin
          if (!trig_pass) yaw_q <= rnd16[34:16];
          trig_aneg <= a_neg;
          trig_cneg <= a_cneg;
          state <= S_CINIT;
        end
        S_CINIT: begin
          cz <= {1'b0, rnd2[34:2]};
          cx <= CORDIC_GAIN;
          cy <= '0;
          cord_i <= '0;
          if (dp_wide > 55'sd2147483647) dp <= 32'sh7fffffff;
          else if (dp_wide < -55'sd2147483648) dp <= 32'sh80000000;
          else dp <= dp_wide[31:0];
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - atv;
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + atv;
          end
          cord_i <= cord_i + 5'd1;
          if (cord_i == 5'(CORDIC_STEPS - 1)) state <= S_CEND;
        end
        S_CEND: begin
          cv <= trig_cneg ? -cx : cx;
          sv <= trig_aneg ? -cy : cy;
          state <= trig_pass ? S_FSET : S_PX;
        end
        S_PX: state <= S_PY;
        S_PY: begin
          acc_x <= sat32(accx_sum);
          state <= S_ACCY;
        end
        S_ACCY: begin
          acc_y <= sat32(accy_sum);
          state <= (us_q == 24'd0) ? S_DONE : S_V2;
        end
        S_V2: begin
          macc <= prod_lo;
          state <= S_V3;
        end
        S_V3: begin
          div_num <= DIV_W'(macc + prod_sh32);
          div_den <= {8'b0, us_q, 8'b0};
          div_rem <= '0;
          div_cnt <= '0;
          div_op <= DIV_V0;
          state <= S_DIV;
        end
        S_DIV: begin
          div_num <= {div_num[DIV_W-2:0], !rem_d[41]};
          div_rem <= rem_d[41] ? rem_s : rem_d[40:0];
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'(DIV_W - 1)) state <= S_DIVEND;
        end
        S_DIVEND: begin
          case (div_op)
            DIV_V0: begin
              v0 <= (div_num > 74'(V0_CAP)) ? V0_CAP : div_num[40:0];
              if (n_zero) begin
                lin_q <= sigmag((div_num > 74'(V0_CAP)) ? 74'(V0_CAP) : div_num,
                                dist_q[53]);
                state <= S_DONE;
              end else begin
                state <= S_N1;
              end
            end
            DIV_F: begin
              f_q <= (div_num > 74'(F_CAP)) ? F_CAP : div_num[49:0];
              state <= S_A1;
            end
            DIV_ANG: begin
              ang_q <= sigmag(div_num, n_neg);
              state <= S_M1;
            end
            default: state <= S_DONE;
          endcase
        end
        S_N1: state <= S_N2;
        S_N2: begin
          dth <= rnd2[34:2];
          trig_h <= an;
          trig_pass <= 1'b1;
          state <= S_TZ;
        end
        S_FSET: begin
          if (sv == 34'sd0) begin
            f_q <= F_CAP;
            state <= S_A1;
          end else begin
            div_num <= {25'b0, dth, 16'b0};
            div_den <= {5'b0, smag, 1'b0};
            div_rem <= '0;
            div_cnt <= '0;
            div_op <= DIV_F;
            state <= S_DIV;
          end
        end
        S_A1: state <= S_A2;
        S_A2: begin
          div_num <= {21'b0, prod_q[52:0]};
          div_den <= {2'b0, us_q, 14'b0};
          div_rem <= '0;
          div_cnt <= '0;
          div_op <= DIV_ANG;
          state <= S_DIV;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          macc <= prod_lo;
          state <= S_M3;
        end
        S_M3: begin
          macc <= macc + prod_sh32;
          state <= S_M4;
        end
        S_M4: begin
          macc <= macc + prod_sh32;
          state <= S_M5;
        end
        S_M5: begin
          macc <= macc + prod_sh64;
          state <= S_M6;
        end
        S_M6: begin
          // A product of 2^47 or more saturates the speed.
          lin_q <= sigmag((macc >= (96'd1 << 47)) ? 74'd2147483648 : {43'b0, macc[46:16]},
                          dist_q[53] ^ n_neg ^ sv[33]);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.pos_x <= acc_x;
            out_data.pos_y <= acc_y;
            out_data.yaw_rad <= yaw_q;
            out_data.lin_vel <= lin_q;
            out_data.ang_vel <= ang_q;
            out_valid <= 1'b1;
            last_left <= l_q;
            last_right <= r_q;
            last_heading <= h_q;
            first_seen <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/wio_checker.sv
// Port-level checker of the wheel and IMU odometry unit, bound to its top level.
// Depends on wio_pkg and wheel_imu_odometry_unit_defines.svh.
`include "wheel_imu_odometry_unit_defines.svh"

module wio_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input wio_pkg::odo_out_t out_data
);
  import wio_pkg::*;

  // A stalled result item holds its value.
  `WIO_ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // The sequencer is busy right after it takes an item.
  `WIO_ASSERT_NEXT(busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // Yaw never exceeds two pi in Q3.16.
  `WIO_ASSERT_SAME(yaw_range, clk, rst, out_valid, out_data.yaw_rad <= 19'd411775)

endmodule

bind wheel_imu_odometry_unit wio_checker u_wio_checker (.*);
